// ----- hw/rtl/text_cell_draw_engine_assert.svh -----
// assertion helpers for the rtl top, text_cell_draw_engine.sv
`ifndef TEXT_CELL_DRAW_ENGINE_ASSERT_SVH
`define TEXT_CELL_DRAW_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off while in reset
`define TCDE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off while in reset
`define TCDE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/tcde_pkg.sv -----
package tcde_pkg;

  // default screen geometry
  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  // field widths
  localparam int unsigned CRD_W  = 8;   // clipped coordinate, up to 255
  localparam int unsigned ATTR_W = 7;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CELL_W = 16;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 7'h07;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  // configuration register addresses
  localparam logic [1:0] REG_ATTR = 2'd0;

  // command codes
  typedef enum logic [3:0] {
    FN_CHAR   = 4'd0,
    FN_HLINE  = 4'd1,
    FN_VLINE  = 4'd2,
    FN_BOX    = 4'd3,
    FN_RECT   = 4'd4,
    FN_CLRROW = 4'd5,
    FN_FILL   = 4'd6,
    FN_INVROW = 4'd7,
    FN_READ   = 4'd8
  } func_e;

  // what the sequencer does over the region
  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_INVERT = 2'd1,
    OP_READ   = 2'd2
  } op_e;

  // decoded command handed to the sequencer
  typedef struct packed {
    logic              ok;
    op_e               op;
    logic              border;
    logic [CRD_W-1:0]  x_lo;
    logic [CRD_W-1:0]  x_hi;
    logic [CRD_W-1:0]  y_lo;
    logic [CRD_W-1:0]  y_hi;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // result of one request
  typedef struct packed {
    logic              done;
    logic              drew;
    logic [CELL_W-1:0] cell_value;
  } rsp_t;

  // swap fg into bg, keep blink, fold old fg bit 3 into blink
  function automatic logic [7:0] invert_attr(logic [7:0] a);
    invert_attr = {a[3:0], 4'b0000} | {5'b00000, a[6:4]} | {a[7], 7'b0000000};
  endfunction

endpackage

// ----- hw/rtl/text_cell_draw_engine.sv -----
// channel   direction  handshake                  payload
// command   in         start & !busy              func_i, x/y_first_i, x/y_second_i, fill_char_i
// result    out        done_o, one cycle          drew_o, cell_value_o
// config    in         psel & penable & pwrite    paddr, pwdata (text attribute at 0)
//
// after reset the cell store is cleared, one cell a cycle, and busy stays high until it is done
// an accepted request runs its sweep states, then S_RESP, from which the result is registered
// a box sweeps its whole rectangle and writes only the border cells
// invert row reads and then writes back each cell of its row; read cell reads one cell
// a rejected request goes from accept straight to S_RESP, writing nothing
// the store's shared read and write address sets the rate; done_o cannot be held off by the receiver
module text_cell_draw_engine #(
  parameter int unsigned COLUMNS = tcde_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcde_pkg::ROWS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [3:0]        func_i,
  input  logic signed [8:0] x_first_i,
  input  logic signed [8:0] y_first_i,
  input  logic signed [8:0] x_second_i,
  input  logic signed [8:0] y_second_i,
  input  logic [7:0]        fill_char_i,
  output logic              done_o,
  output logic              drew_o,
  output logic [15:0]       cell_value_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [1:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  import tcde_pkg::*;

`include "text_cell_draw_engine_assert.svh"

  logic              attr_we;
  logic [ATTR_W-1:0] text_attr_q;
  logic              cmd_valid;
  cmd_t              cmd;
  rsp_t              rsp;

  // text attribute register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q <= ATTR_RESET;
    end else if (attr_we) begin
      text_attr_q <= pwdata[ATTR_W-1:0];
    end
  end

  assign attr_we = psel && penable && pwrite && pready && (paddr == REG_ATTR);
  assign pready = 1'b1;
  assign prdata = (paddr == REG_ATTR) ? {{(32-ATTR_W){1'b0}}, text_attr_q} : '0;

  // command decode
  tcde_decode #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_decode (
    .func_i     (func_i),
    .x_first_i  (x_first_i),
    .y_first_i  (y_first_i),
    .x_second_i (x_second_i),
    .y_second_i (y_second_i),
    .fill_char_i(fill_char_i),
    .cmd_o      (cmd)
  );

  assign cmd_valid = start && !busy;

  // store sequencer
  tcde_seq #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .attr_i      (text_attr_q),
    .busy_o      (busy),
    .rsp_o       (rsp)
  );

  assign done_o       = rsp.done;
  assign drew_o       = rsp.drew;
  assign cell_value_o = rsp.cell_value;

  // checks
  `TCDE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
  `TCDE_ASSERT_NXT(a_done_pulse, done_o, !done_o, "result strobe held longer than one cycle")
  `TCDE_ASSERT_IMP(a_done_idle, done_o, !busy, "result shown while still busy")
  `TCDE_ASSERT_IMP(a_reject_zero, done_o && !drew_o, cell_value_o == '0,
    "rejected request returned a cell value")

endmodule

// ----- hw/rtl/tcde_ram.sv -----
module tcde_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/tcde_decode.sv -----
module tcde_decode #(
  parameter int unsigned COLUMNS = tcde_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcde_pkg::ROWS_DEF
) (
  input  logic [3:0]        func_i,
  input  logic signed [8:0] x_first_i,
  input  logic signed [8:0] y_first_i,
  input  logic signed [8:0] x_second_i,
  input  logic signed [8:0] y_second_i,
  input  logic [7:0]        fill_char_i,
  output tcde_pkg::cmd_t    cmd_o
);

  import tcde_pkg::*;

  localparam logic signed [9:0] COLS_S = 10'(COLUMNS);
  localparam logic signed [9:0] ROWS_S = 10'(ROWS);
  localparam logic [CRD_W-1:0]  X_MAX  = CRD_W'(COLUMNS - 1);
  localparam logic [CRD_W-1:0]  Y_MAX  = CRD_W'(ROWS - 1);

  // clamp a coordinate into 0 .. lim-1
  function automatic logic [CRD_W-1:0] clip_to(logic signed [9:0] v, logic signed [9:0] lim);
    logic signed [9:0] top;
    top = lim - 10'sd1;
    if (v < 10'sd0) begin
      clip_to = '0;
    end else if (v >= lim) begin
      clip_to = top[CRD_W-1:0];
    end else begin
      clip_to = v[CRD_W-1:0];
    end
  endfunction

  logic signed [9:0] x1, y1, x2, y2;
  logic signed [9:0] xa, xb, ya, yb;
  logic              x1_on, y1_on, rect_ok;

  assign x1 = $signed({x_first_i[8], x_first_i});
  assign y1 = $signed({y_first_i[8], y_first_i});
  assign x2 = $signed({x_second_i[8], x_second_i});
  assign y2 = $signed({y_second_i[8], y_second_i});

  // sorted line endpoints
  assign xa = (x1 > x2) ? x2 : x1;
  assign xb = (x1 > x2) ? x1 : x2;
  assign ya = (y1 > y2) ? y2 : y1;
  assign yb = (y1 > y2) ? y1 : y2;

  assign x1_on   = (x1 >= 10'sd0) && (x1 < COLS_S);
  assign y1_on   = (y1 >= 10'sd0) && (y1 < ROWS_S);
  assign rect_ok = (x1 >= 10'sd0) && (y1 >= 10'sd0) && (x2 < COLS_S) && (y2 < ROWS_S) &&
                   (x2 >= x1) && (y2 >= y1);

  // command to region and operation
  always_comb begin
    cmd_o        = '0;
    cmd_o.op     = OP_WRITE;
    cmd_o.ch     = fill_char_i;
    cmd_o.x_lo   = x1[CRD_W-1:0];
    cmd_o.x_hi   = x1[CRD_W-1:0];
    cmd_o.y_lo   = y1[CRD_W-1:0];
    cmd_o.y_hi   = y1[CRD_W-1:0];
    case (func_e'(func_i))
      FN_CHAR: begin
        cmd_o.ok = x1_on && y1_on;
      end
      FN_HLINE: begin
        cmd_o.ok   = y1_on && (xb >= 10'sd0) && (xa < COLS_S);
        cmd_o.x_lo = clip_to(xa, COLS_S);
        cmd_o.x_hi = clip_to(xb, COLS_S);
      end
      FN_VLINE: begin
        cmd_o.ok   = x1_on && (yb >= 10'sd0) && (ya < ROWS_S);
        cmd_o.y_lo = clip_to(ya, ROWS_S);
        cmd_o.y_hi = clip_to(yb, ROWS_S);
      end
      FN_BOX, FN_RECT: begin
        cmd_o.ok     = rect_ok;
        cmd_o.border = (func_e'(func_i) == FN_BOX);
        cmd_o.x_hi   = x2[CRD_W-1:0];
        cmd_o.y_hi   = y2[CRD_W-1:0];
      end
      FN_CLRROW: begin
        cmd_o.ok   = y1_on;
        cmd_o.ch   = SPACE_CHAR;
        cmd_o.x_lo = '0;
        cmd_o.x_hi = X_MAX;
      end
      FN_FILL: begin
        cmd_o.ok   = 1'b1;
        cmd_o.x_lo = '0;
        cmd_o.x_hi = X_MAX;
        cmd_o.y_lo = '0;
        cmd_o.y_hi = Y_MAX;
      end
      FN_INVROW: begin
        cmd_o.ok   = y1_on;
        cmd_o.op   = OP_INVERT;
        cmd_o.x_lo = '0;
        cmd_o.x_hi = X_MAX;
      end
      FN_READ: begin
        cmd_o.ok = x1_on && y1_on;
        cmd_o.op = OP_READ;
      end
      default: begin
        cmd_o.ok = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/tcde_seq.sv -----
module tcde_seq #(
  parameter int unsigned COLUMNS = tcde_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tcde_pkg::ROWS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  tcde_pkg::cmd_t                cmd_i,
  input  logic [tcde_pkg::ATTR_W-1:0]   attr_i,
  output logic                          busy_o,
  output tcde_pkg::rsp_t                rsp_o
);

  import tcde_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * ROWS;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [15:0]   COLS16    = 16'(COLUMNS);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_WRITE  = 7'b0000100,
    S_INV_RD = 7'b0001000,
    S_INV_WR = 7'b0010000,
    S_READ   = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [CRD_W-1:0]  x_q, x_d, y_q, y_d;
  logic [AW-1:0]     clr_q, clr_d;
  rsp_t              rsp_q, rsp_d;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_addr;
  logic [CELL_W-1:0] mem_wdata, mem_rdata;
  logic [15:0]       lin;
  logic              x_end, y_end, on_border;
  logic [7:0]        inv_attr;

  // cell store
  tcde_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_addr),
    .rdata_o (mem_rdata)
  );

  // linear cell address of the sweep position
  assign lin       = 16'(y_q) * COLS16 + 16'(x_q);
  assign x_end     = (x_q == cmd_q.x_hi);
  assign y_end     = (y_q == cmd_q.y_hi);
  assign on_border = (x_q == cmd_q.x_lo) || x_end || (y_q == cmd_q.y_lo) || y_end;
  assign inv_attr  = invert_attr(mem_rdata[15:8]);

  // sweep sequencer
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    x_d       = x_q;
    y_d       = y_q;
    clr_d     = clr_q;
    rsp_d     = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = lin[AW-1:0];
    mem_wdata = {1'b0, attr_i, cmd_q.ch};
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_d = cmd_i;
          x_d   = cmd_i.x_lo;
          y_d   = cmd_i.y_lo;
          if (!cmd_i.ok) begin
            state_d = S_RESP;
          end else begin
            case (cmd_i.op)
              OP_WRITE:  state_d = S_WRITE;
              OP_INVERT: state_d = S_INV_RD;
              OP_READ:   state_d = S_READ;
              default:   state_d = S_RESP;
            endcase
          end
        end
      end
      S_WRITE: begin
        mem_we = !cmd_q.border || on_border;
        if (x_end) begin
          x_d = cmd_q.x_lo;
          if (y_end) begin
            state_d = S_RESP;
          end else begin
            y_d = y_q + CRD_W'(1);
          end
        end else begin
          x_d = x_q + CRD_W'(1);
        end
      end
      S_INV_RD: begin
        mem_re  = 1'b1;
        state_d = S_INV_WR;
      end
      S_INV_WR: begin
        mem_we    = 1'b1;
        mem_wdata = {inv_attr, mem_rdata[7:0]};
        if (x_end) begin
          state_d = S_RESP;
        end else begin
          x_d     = x_q + CRD_W'(1);
          state_d = S_INV_RD;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        rsp_d.done = 1'b1;
        rsp_d.drew = cmd_q.ok;
        if (cmd_q.ok && (cmd_q.op == OP_READ)) begin
          rsp_d.cell_value = mem_rdata;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      rsp_q   <= rsp_d;
    end
  end

  // command and sweep position
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign rsp_o  = rsp_q;

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcde_pkg::*;

  localparam int SCREEN_COLS = COLUMNS_DEF;
  localparam int SCREEN_ROWS = ROWS_DEF;
  localparam logic [3:0] FN_UNUSED_LO = 4'd9;
  localparam logic [3:0] FN_UNUSED_HI = 4'd15;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_REQUESTS = 50;
  localparam int QUIET_PHASE = 2;

  // cell store mirror, current attribute and the outcomes still owed by the block
  class draw_scoreboard;
    typedef struct {
      logic        drew;
      logic [15:0] value;
    } outcome_t;

    logic [15:0] cells [SCREEN_COLS*SCREEN_ROWS];
    logic [6:0]  attr;
    outcome_t    pending[$];
    int          mismatches;
    int          checked;
    int          accepted;

    function void clear();
      foreach (cells[i]) cells[i] = '0;
      attr = ATTR_RESET;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void paint(int x, int y, logic [7:0] ch);
      if (x >= 0 && x < SCREEN_COLS && y >= 0 && y < SCREEN_ROWS)
        cells[y*SCREEN_COLS + x] = {1'b0, attr, ch};
    endfunction

    // sorted, clipped horizontal span; 0 when nothing lands on screen
    function bit paint_row_span(int y, int a, int b, logic [7:0] ch);
      int t;
      if (y < 0 || y >= SCREEN_ROWS) return 0;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      if (b < 0 || a >= SCREEN_COLS) return 0;
      if (a < 0) a = 0;
      if (b >= SCREEN_COLS) b = SCREEN_COLS - 1;
      for (int x = a; x <= b; x++) paint(x, y, ch);
      return 1;
    endfunction

    function bit paint_col_span(int x, int a, int b, logic [7:0] ch);
      int t;
      if (x < 0 || x >= SCREEN_COLS) return 0;
      if (a > b) begin
        t = a; a = b; b = t;
      end
      if (b < 0 || a >= SCREEN_ROWS) return 0;
      if (a < 0) a = 0;
      if (b >= SCREEN_ROWS) b = SCREEN_ROWS - 1;
      for (int y = a; y <= b; y++) paint(x, y, ch);
      return 1;
    endfunction

    // apply one accepted request to the mirror and queue its outcome
    function void note_request(logic [3:0] fn, logic signed [8:0] xa, logic signed [8:0] ya,
                               logic signed [8:0] xb, logic signed [8:0] yb,
                               logic [7:0] ch);
      int          x1;
      int          y1;
      int          x2;
      int          y2;
      bit          ok;
      bit          fits;
      bit          cell_on;
      bit          row_on;
      logic [15:0] val;
      logic [7:0]  a;
      int          idx;
      x1 = xa;
      y1 = ya;
      x2 = xb;
      y2 = yb;
      ok = 0;
      val = '0;
      row_on = (y1 >= 0 && y1 < SCREEN_ROWS);
      cell_on = row_on && x1 >= 0 && x1 < SCREEN_COLS;
      fits = x1 >= 0 && y1 >= 0 && x2 < SCREEN_COLS && y2 < SCREEN_ROWS &&
             x2 >= x1 && y2 >= y1;
      case (fn)
        FN_CHAR: begin
          if (cell_on) begin
            paint(x1, y1, ch);
            ok = 1;
          end
        end
        FN_HLINE: ok = paint_row_span(y1, x1, x2, ch);
        FN_VLINE: ok = paint_col_span(x1, y1, y2, ch);
        FN_BOX: begin
          if (fits) begin
            void'(paint_row_span(y1, x1, x2, ch));
            void'(paint_row_span(y2, x1, x2, ch));
            void'(paint_col_span(x1, y1, y2, ch));
            void'(paint_col_span(x2, y1, y2, ch));
            ok = 1;
          end
        end
        FN_RECT: begin
          if (fits) begin
            for (int y = y1; y <= y2; y++)
              for (int x = x1; x <= x2; x++) paint(x, y, ch);
            ok = 1;
          end
        end
        FN_CLRROW: begin
          if (row_on) begin
            for (int x = 0; x < SCREEN_COLS; x++) paint(x, y1, SPACE_CHAR);
            ok = 1;
          end
        end
        FN_FILL: begin
          for (int y = 0; y < SCREEN_ROWS; y++)
            for (int x = 0; x < SCREEN_COLS; x++) paint(x, y, ch);
          ok = 1;
        end
        FN_INVROW: begin
          // fg moves to bg, old bg to fg; bit 7 keeps blink or picks up fg bit 3
          if (row_on) begin
            for (int x = 0; x < SCREEN_COLS; x++) begin
              idx = y1*SCREEN_COLS + x;
              a = cells[idx][15:8];
              cells[idx][15:8] = {a[3] | a[7], a[2:0], 1'b0, a[6:4]};
            end
            ok = 1;
          end
        end
        FN_READ: begin
          if (cell_on) begin
            val = cells[y1*SCREEN_COLS + x1];
            ok = 1;
          end
        end
        default: ;
      endcase
      pending.push_back('{ok, val});
    endfunction

    // compare one result strobe with the oldest outcome owed
    function void check_result(logic drew, logic [15:0] value);
      outcome_t want;
      checked++;
      if (drew === 1'b1) accepted++;
      if (pending.size() == 0) begin
        flag($sformatf("result %0d with no request outstanding: drew %b cell_value %h",
                       checked, drew, value));
        return;
      end
      want = pending.pop_front();
      if (drew !== want.drew || value !== want.value)
        flag($sformatf("result %0d: drew exp %b got %b, cell_value exp %h got %h",
                       checked, want.drew, drew, want.value, value));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [3:0]        func_i = FN_CHAR;
  logic signed [8:0] x_first_i = '0;
  logic signed [8:0] y_first_i = '0;
  logic signed [8:0] x_second_i = '0;
  logic signed [8:0] y_second_i = '0;
  logic [7:0]        fill_char_i = '0;
  logic              done_o;
  logic              drew_o;
  logic [15:0]       cell_value_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [1:0]        paddr = REG_ATTR;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  draw_scoreboard sb;
  int             n_requests = 0;
  int             n_settings = 1;

  text_cell_draw_engine dut (.*);

  always #1 clk_i = ~clk_i;

  // result strobes cannot be held off, so every one is checked on the spot
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(drew_o, cell_value_o);
  end

  // run limit, well above the slowest legal run
  initial begin
    #4_000_000;
    $display("timeout with %0d results still owed", sb.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic signed [8:0] rand_coord(int span);
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 9'($urandom_range(0, span - 1));
    if (r < 85) return 9'(span + $urandom_range(0, 2));
    if (r < 92) return 9'(-int'($urandom_range(1, 3)));
    return 9'($urandom);
  endfunction

  // hold the request until the block takes it, then mirror it
  task automatic send_request(logic [3:0] fn, logic signed [8:0] xa, logic signed [8:0] ya,
                              logic signed [8:0] xb, logic signed [8:0] yb,
                              logic [7:0] ch);
    start       <= 1'b1;
    func_i      <= fn;
    x_first_i   <= xa;
    y_first_i   <= ya;
    x_second_i  <= xb;
    y_second_i  <= yb;
    fill_char_i <= ch;
    do @(posedge clk_i); while (busy);
    sb.note_request(fn, xa, ya, xb, yb, ch);
    n_requests++;
  endtask

  task automatic idle_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || sb.pending.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_attr_readback(logic [6:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_ATTR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {25'd0, want})
      sb.flag($sformatf("attribute readback exp %h got %h", {25'd0, want}, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_attr(logic [6:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ATTR;
    pwdata  <= {25'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    sb.attr = value;
    n_settings++;
    check_attr_readback(value);
  endtask

  initial begin
    logic [6:0]        phase_attr;
    logic [3:0]        fn;
    logic signed [8:0] xa;
    logic signed [8:0] ya;
    logic signed [8:0] xb;
    logic signed [8:0] yb;
    logic [7:0]        ch;
    int                r;
    sb = new();
    sb.clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // the store clears itself after reset
    while (busy) @(posedge clk_i);
    check_attr_readback(ATTR_RESET);
    @(posedge clk_i);

    // directed requests at the reset attribute
    send_request(FN_READ,   0,    0,    0,    0,    8'h00);
    send_request(FN_CHAR,   0,    0,    0,    0,    8'h41);
    send_request(FN_CHAR,   79,   24,   0,    0,    8'hFF);
    send_request(FN_CHAR,   80,   0,    0,    0,    8'h42);
    send_request(FN_CHAR,   0,    25,   0,    0,    8'h43);
    send_request(FN_READ,   79,   24,   0,    0,    8'h00);
    send_request(FN_HLINE,  90,   2,    -5,   0,    8'h2D);
    send_request(FN_HLINE,  0,    -256, 10,   0,    8'h2D);
    send_request(FN_HLINE,  100,  3,    200,  0,    8'h2D);
    send_request(FN_VLINE,  3,    30,   0,    -10,  8'h7C);
    send_request(FN_VLINE,  80,   0,    0,    5,    8'h7C);
    send_request(FN_BOX,    10,   5,    20,   10,   8'h23);
    send_request(FN_BOX,    20,   5,    10,   10,   8'h23);
    send_request(FN_BOX,    0,    0,    79,   24,   8'h00);
    send_request(FN_RECT,   30,   12,   79,   24,   8'h55);
    send_request(FN_RECT,   0,    0,    5,    25,   8'h55);
    send_request(FN_CLRROW, 0,    5,    0,    0,    8'h00);
    send_request(FN_CLRROW, 0,    25,   0,    0,    8'h00);
    send_request(FN_INVROW, 0,    2,    0,    0,    8'h00);
    send_request(FN_INVROW, 0,    2,    0,    0,    8'h00);
    send_request(FN_INVROW, 0,    -1,   0,    0,    8'h00);
    send_request(FN_READ,   3,    2,    0,    0,    8'h00);
    send_request(FN_FILL,   255,  -256, -256, 255,  8'h2E);
    send_request(FN_UNUSED_LO, 1, 1,    2,    2,    8'h11);
    send_request(FN_UNUSED_HI, 1, 1,    2,    2,    8'h11);
    send_request(FN_READ,   -256, 255,  0,    0,    8'h00);

    // random phases, each under its own attribute
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_quiet();
      case (phase)
        0:       phase_attr = 7'h7F;
        1:       phase_attr = 7'h00;
        default: phase_attr = 7'($urandom_range(0, 127));
      endcase
      write_attr(phase_attr);
      @(posedge clk_i);
      for (int k = 0; k < PHASE_REQUESTS; k++) begin
        if (phase != QUIET_PHASE && $urandom_range(0, 99) < 22) idle_gap();
        // unused fields carry noise
        xa = 9'($urandom);
        ya = 9'($urandom);
        xb = 9'($urandom);
        yb = 9'($urandom);
        ch = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 18) begin
          fn = FN_READ;
          xa = rand_coord(SCREEN_COLS);
          ya = rand_coord(SCREEN_ROWS);
        end else if (r < 36) begin
          fn = FN_CHAR;
          xa = rand_coord(SCREEN_COLS);
          ya = rand_coord(SCREEN_ROWS);
        end else if (r < 48) begin
          fn = FN_HLINE;
          ya = rand_coord(SCREEN_ROWS);
          xa = rand_coord(SCREEN_COLS);
          xb = rand_coord(SCREEN_COLS);
        end else if (r < 60) begin
          fn = FN_VLINE;
          xa = rand_coord(SCREEN_COLS);
          ya = rand_coord(SCREEN_ROWS);
          yb = rand_coord(SCREEN_ROWS);
        end else if (r < 78) begin
          // mostly small rectangles, now and then an arbitrary corner pair
          fn = (r < 69) ? FN_BOX : FN_RECT;
          xa = rand_coord(SCREEN_COLS);
          ya = rand_coord(SCREEN_ROWS);
          if ($urandom_range(0, 9) == 0) begin
            xb = rand_coord(SCREEN_COLS);
            yb = rand_coord(SCREEN_ROWS);
          end else begin
            xb = 9'(int'(xa) + $urandom_range(0, 7));
            yb = 9'(int'(ya) + $urandom_range(0, 4));
          end
        end else if (r < 83) begin
          fn = FN_CLRROW;
          ya = rand_coord(SCREEN_ROWS);
        end else if (r < 91) begin
          fn = FN_INVROW;
          ya = rand_coord(SCREEN_ROWS);
        end else if (r < 93) begin
          fn = FN_FILL;
        end else begin
          fn = 4'($urandom_range(FN_UNUSED_LO, FN_UNUSED_HI));
        end
        send_request(fn, xa, ya, xb, yb, ch);
      end
    end

    // drain, then leave room for any stray strobe
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("covered %0d requests, %0d results (%0d drew), %0d attribute settings",
             n_requests, sb.checked, sb.accepted, n_settings);
    $display("all commands, clipping and rejection cases, reads after draws and inverts");
    if (sb.mismatches == 0 && sb.checked == n_requests) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results for %0d requests",
               sb.mismatches, sb.checked, n_requests);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
